// ===== rtl/mse_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mse_pkg
// Shared types and constants for the MIPS subset execute block.
// ============================================================================
package mse_pkg;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_OR   = 5'd2,
        OP_AND  = 5'd3,
        OP_SLT  = 5'd4,
        OP_SLL  = 5'd5,
        OP_SRL  = 5'd6,
        OP_JR   = 5'd7,
        OP_LW   = 5'd8,
        OP_SW   = 5'd9,
        OP_ADDI = 5'd10,
        OP_ORI  = 5'd11,
        OP_ANDI = 5'd12,
        OP_SLTI = 5'd13,
        OP_BEQ  = 5'd14,
        OP_BNE  = 5'd15,
        OP_LUI  = 5'd16,
        OP_J    = 5'd17,
        OP_JAL  = 5'd18
    } op_t;

    localparam int          DATA_WORDS_DEF = 1024;
    localparam logic [4:0]  LINK_REG       = 5'd31;
    localparam logic [31:0] PC_STEP        = 32'd4;
    localparam int          REGION_BITS    = 4;
    localparam int          LUI_SHIFT      = 16;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        written;
        logic [4:0]  written_reg;
        logic [31:0] written_value;
        logic        is_load;
        logic        stored;
        logic        branch_taken;
        logic [31:0] store_data;
    } stage_t;

endpackage

// ===== rtl/mips_subset_execute_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mips_subset_execute_top
// Executes one decoded MIPS32 subset instruction per word: register file,
// program counter and word-addressed data store.
// ============================================================================
// Accepts one word per cycle unless a load hazard or a low out_ready stalls
// it; each word passes decode/execute, two multiplier stages that reduce the
// data word address modulo DATA_WORDS, data memory access and the output
// register. Register results are forwarded from every stage, so dependent
// words issue back to back; a word that reads a register loaded by an lw
// still in the address reduction or memory access stages waits until the
// load data reaches the output register. The register file reads as zero
// after reset through per-entry valid bits; no clearing pass is needed.
module mips_subset_execute_top #(
    parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         op,
    input  logic [4:0]         source_a,
    input  logic [4:0]         source_b,
    input  logic [4:0]         dest,
    input  logic [4:0]         shift_amount,
    input  logic signed [15:0] immediate,
    input  logic [25:0]        jump_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        next_pc,
    output logic               written,
    output logic [4:0]         written_reg,
    output logic [31:0]        written_value,
    output logic               stored,
    output logic               branch_taken
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam int RW = AW + 1;
    localparam int MW = 31 - AW;
    localparam int PW = 30 + MW;
    localparam int QW = MW + RW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << 30) / DATA_WORDS);
    localparam logic [RW-1:0] N_R   = RW'(DATA_WORDS);

    typedef struct packed {
        logic        stall;
        logic [31:0] value;
    } fwd_t;

    // stage 1
    logic              s1_vld_reg;
    logic [4:0]        s1_op_reg;
    logic [4:0]        s1_ra_reg;
    logic [4:0]        s1_rb_reg;
    logic [4:0]        s1_rd_reg;
    logic [4:0]        s1_sa_reg;
    logic [15:0]       s1_imm_reg;
    logic [25:0]       s1_idx_reg;
    logic [31:0]       pc_reg;

    logic [31:0]       rf_mem [0:31];
    logic [31:0]       rf_vld_reg;
    logic [31:0]       rf_a_reg;
    logic [31:0]       rf_b_reg;
    logic              rf_a_ok_reg;
    logic              rf_b_ok_reg;
    logic [4:0]        rd_addr_a;
    logic [4:0]        rd_addr_b;

    logic              byp_wr_reg;
    logic [4:0]        byp_reg_reg;
    logic [31:0]       byp_val_reg;

    logic              s2_vld_reg;
    mse_pkg::stage_t   s2_reg;
    logic [29:0]       s2_addr_reg;
    logic              s3_vld_reg;
    mse_pkg::stage_t   s3_reg;
    logic [PW-1:0]     s3_prod_reg;
    logic [RW-1:0]     s3_lo_reg;
    logic              s4_vld_reg;
    mse_pkg::stage_t   s4_reg;
    logic [RW-1:0]     s4_qn_reg;
    logic [RW-1:0]     s4_lo_reg;
    logic              s5_vld_reg;
    mse_pkg::stage_t   s5_reg;

    logic [31:0]       dm_mem [0:DATA_WORDS-1];
    logic [31:0]       dm_rdata_reg;

    logic              en2;
    logic              en3;
    logic              en4;
    logic              en5;
    logic              hazard;
    logic              s1_go;
    logic              accept;
    logic              retire;
    logic [31:0]       res_val;
    fwd_t              fa;
    fwd_t              fb;
    mse_pkg::stage_t   s1_res;
    logic [29:0]       s1_addr;
    logic [PW-1:0]     prod_next;
    logic [QW-1:0]     qn_full;
    logic [RW-1:0]     r_est;
    logic [RW-1:0]     r_fix;
    logic [AW-1:0]     dm_idx;
    logic              dm_go;

    function automatic fwd_t fwd_sel(
        input logic [4:0]      r,
        input logic [31:0]     rf_d,
        input logic            rf_ok,
        input logic            bw,
        input logic [4:0]      breg,
        input logic [31:0]     bval,
        input logic            v5,
        input mse_pkg::stage_t st5,
        input logic [31:0]     val5,
        input logic            v4,
        input mse_pkg::stage_t st4,
        input logic            v3,
        input mse_pkg::stage_t st3,
        input logic            v2,
        input mse_pkg::stage_t st2
    );
        fwd_t f;
        f.value = rf_ok ? rf_d : 32'd0;
        f.stall = 1'b0;
        if (bw && breg == r)
        begin
            f.value = bval;
        end
        if (v5 && st5.written && st5.written_reg == r)
        begin
            f.value = val5;
        end
        if (v4 && st4.written && st4.written_reg == r)
        begin
            f.value = st4.written_value;
            f.stall = st4.is_load;
        end
        if (v3 && st3.written && st3.written_reg == r)
        begin
            f.value = st3.written_value;
            f.stall = st3.is_load;
        end
        if (v2 && st2.written && st2.written_reg == r)
        begin
            f.value = st2.written_value;
            f.stall = st2.is_load;
        end
        return f;
    endfunction

    // handshake and pipeline advance
    assign en5    = !s5_vld_reg || out_ready;
    assign en4    = !s4_vld_reg || en5;
    assign en3    = !s3_vld_reg || en4;
    assign en2    = !s2_vld_reg || en3;
    assign hazard = s1_vld_reg && (fa.stall || fb.stall);
    assign s1_go  = s1_vld_reg && en2 && !hazard;
    assign in_ready = !s1_vld_reg || s1_go;
    assign accept = in_valid && in_ready;
    assign retire = s5_vld_reg && out_ready;
    assign dm_go  = s4_vld_reg && en5;

    assign res_val = s5_reg.is_load ? dm_rdata_reg : s5_reg.written_value;

    assign rd_addr_a = accept ? source_a : s1_ra_reg;
    assign rd_addr_b = accept ? source_b : s1_rb_reg;

    always_comb
    begin
        fa = fwd_sel(s1_ra_reg, rf_a_reg, rf_a_ok_reg, byp_wr_reg, byp_reg_reg,
                     byp_val_reg, s5_vld_reg, s5_reg, res_val, s4_vld_reg, s4_reg,
                     s3_vld_reg, s3_reg, s2_vld_reg, s2_reg);
        fb = fwd_sel(s1_rb_reg, rf_b_reg, rf_b_ok_reg, byp_wr_reg, byp_reg_reg,
                     byp_val_reg, s5_vld_reg, s5_reg, res_val, s4_vld_reg, s4_reg,
                     s3_vld_reg, s3_reg, s2_vld_reg, s2_reg);
    end

    // execute
    always_comb
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] seq;
        logic [31:0] br_tgt;
        logic [31:0] jmp_tgt;
        logic [31:0] sum;
        a       = fa.value;
        b       = fb.value;
        simm    = {{16{s1_imm_reg[15]}}, s1_imm_reg};
        zimm    = {16'd0, s1_imm_reg};
        seq     = pc_reg + mse_pkg::PC_STEP;
        br_tgt  = seq + {simm[29:0], 2'b00};
        jmp_tgt = {seq[31:32-mse_pkg::REGION_BITS], s1_idx_reg, 2'b00};
        sum     = a + simm;
        s1_addr = sum[31:2];

        s1_res               = '0;
        s1_res.next_pc       = seq;
        s1_res.store_data    = b;
        case (s1_op_reg)
            mse_pkg::OP_ADD:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = a + b;
            end
            mse_pkg::OP_SUB:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = a - b;
            end
            mse_pkg::OP_OR:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = a | b;
            end
            mse_pkg::OP_AND:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = a & b;
            end
            mse_pkg::OP_SLT:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = {31'd0, $signed(a) < $signed(b)};
            end
            mse_pkg::OP_SLL:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = b << s1_sa_reg;
            end
            mse_pkg::OP_SRL:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rd_reg;
                s1_res.written_value = b >> s1_sa_reg;
            end
            mse_pkg::OP_JR:
            begin
                s1_res.next_pc = a; s1_res.branch_taken = 1'b1;
            end
            mse_pkg::OP_LW:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rb_reg;
                s1_res.is_load = 1'b1;
            end
            mse_pkg::OP_SW:
            begin
                s1_res.stored = 1'b1;
            end
            mse_pkg::OP_ADDI:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rb_reg;
                s1_res.written_value = sum;
            end
            mse_pkg::OP_ORI:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rb_reg;
                s1_res.written_value = a | zimm;
            end
            mse_pkg::OP_ANDI:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rb_reg;
                s1_res.written_value = a & zimm;
            end
            mse_pkg::OP_SLTI:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rb_reg;
                s1_res.written_value = {31'd0, $signed(a) < $signed(simm)};
            end
            mse_pkg::OP_BEQ:
            begin
                if (a == b)
                begin
                    s1_res.next_pc = br_tgt; s1_res.branch_taken = 1'b1;
                end
            end
            mse_pkg::OP_BNE:
            begin
                if (a != b)
                begin
                    s1_res.next_pc = br_tgt; s1_res.branch_taken = 1'b1;
                end
            end
            mse_pkg::OP_LUI:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = s1_rb_reg;
                s1_res.written_value = zimm << mse_pkg::LUI_SHIFT;
            end
            mse_pkg::OP_J:
            begin
                s1_res.next_pc = jmp_tgt; s1_res.branch_taken = 1'b1;
            end
            mse_pkg::OP_JAL:
            begin
                s1_res.written = 1'b1; s1_res.written_reg = mse_pkg::LINK_REG;
                s1_res.written_value = seq;
                s1_res.next_pc = jmp_tgt; s1_res.branch_taken = 1'b1;
            end
            default:
            begin
                s1_res.written = 1'b0;
            end
        endcase

        // drop writes to register zero
        if (s1_res.written_reg == 5'd0)
        begin
            s1_res.written = 1'b0;
        end
        if (!s1_res.written)
        begin
            s1_res.written_reg   = 5'd0;
            s1_res.written_value = 32'd0;
            s1_res.is_load       = 1'b0;
        end
    end

    // data word index modulo DATA_WORDS
    assign prod_next = {{MW{1'b0}}, s2_addr_reg} * {{30{1'b0}}, RECIP};
    assign qn_full   = {{RW{1'b0}}, s3_prod_reg[PW-1:30]} * {{MW{1'b0}}, N_R};
    assign r_est     = s4_lo_reg - s4_qn_reg;
    assign r_fix     = (r_est >= N_R) ? (r_est - N_R) : r_est;
    assign dm_idx    = r_fix[AW-1:0];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            pc_reg     <= 32'd0;
            rf_vld_reg <= 32'd0;
            byp_wr_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
            if (en2)
            begin
                s2_vld_reg <= s1_go;
            end
            if (en3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (en5)
            begin
                s5_vld_reg <= s4_vld_reg;
            end
            if (s1_go)
            begin
                pc_reg <= s1_res.next_pc;
            end
            if (retire && s5_reg.written)
            begin
                rf_vld_reg[s5_reg.written_reg] <= 1'b1;
            end
            byp_wr_reg <= retire && s5_reg.written;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= op;
            s1_ra_reg  <= source_a;
            s1_rb_reg  <= source_b;
            s1_rd_reg  <= dest;
            s1_sa_reg  <= shift_amount;
            s1_imm_reg <= immediate;
            s1_idx_reg <= jump_index;
        end
        rf_a_ok_reg <= rf_vld_reg[rd_addr_a];
        rf_b_ok_reg <= rf_vld_reg[rd_addr_b];
        byp_reg_reg <= s5_reg.written_reg;
        byp_val_reg <= res_val;
        if (en2)
        begin
            s2_reg      <= s1_res;
            s2_addr_reg <= s1_addr;
        end
        if (en3)
        begin
            s3_reg      <= s2_reg;
            s3_prod_reg <= prod_next;
            s3_lo_reg   <= s2_addr_reg[RW-1:0];
        end
        if (en4)
        begin
            s4_reg    <= s3_reg;
            s4_qn_reg <= qn_full[RW-1:0];
            s4_lo_reg <= s3_lo_reg;
        end
        if (en5)
        begin
            s5_reg <= s4_reg;
        end
    end

    // register file
    always_ff @(posedge clk)
    begin
        if (retire && s5_reg.written)
        begin
            rf_mem[s5_reg.written_reg] <= res_val;
        end
        rf_a_reg <= rf_mem[rd_addr_a];
        rf_b_reg <= rf_mem[rd_addr_b];
    end

    // data store
    always_ff @(posedge clk)
    begin
        if (dm_go && s4_reg.stored)
        begin
            dm_mem[dm_idx] <= s4_reg.store_data;
        end
        if (dm_go && s4_reg.is_load)
        begin
            dm_rdata_reg <= dm_mem[dm_idx];
        end
    end

    assign out_valid     = s5_vld_reg;
    assign next_pc       = s5_reg.next_pc;
    assign written       = s5_reg.written;
    assign written_reg   = s5_reg.written_reg;
    assign written_value = res_val;
    assign stored        = s5_reg.stored;
    assign branch_taken  = s5_reg.branch_taken;

endmodule

// ===== rtl/mse_check.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mse_check
// Port-level checks for the MIPS subset execute block, bound to the top.
// ============================================================================
module mse_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [4:0]         op,
    input logic [4:0]         source_a,
    input logic [4:0]         source_b,
    input logic [4:0]         dest,
    input logic [4:0]         shift_amount,
    input logic signed [15:0] immediate,
    input logic [25:0]        jump_index,
    input logic               out_valid,
    input logic               out_ready,
    input logic [31:0]        next_pc,
    input logic               written,
    input logic [4:0]         written_reg,
    input logic [31:0]        written_value,
    input logic               stored,
    input logic               branch_taken
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc)
            && $stable(written_value) && $stable(written_reg))
        else $error("result word changed while stalled");

    a_clean_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !written |-> written_reg == 5'd0 && written_value == 32'd0)
        else $error("write fields set without a register write");

    a_no_zero_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> written_reg != 5'd0 && !stored)
        else $error("write to register zero or write with store");

    a_link: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written && branch_taken |-> written_reg == mse_pkg::LINK_REG
            && next_pc[31:28] == written_value[31:28] && next_pc[1:0] == 2'b00)
        else $error("link word does not match jump target region");

endmodule

bind mips_subset_execute_top mse_check u_mse_check (.*);
